// ===== hw/rtl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// shared constants, state encoding and controller/datapath link types for the
// pulse cycle counter
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

   localparam int MAX_WINDOW  = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
   localparam int COUNT_BITS  = 13;
   localparam int PEAK_BITS   = SAMPLE_BITS + 1;
   localparam int TRIPLE_BITS = SAMPLE_BITS + 2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_TRAIL,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic sample_en;
      logic trail_en;
      logic scan_rd;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic peak_empty;
      logic scan_last;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pcc_ram.sv =====
// ----------------------------------------------------------------------------
// pcc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcc_ctrl
// sequencer: sample loading, trailing peak, peak scan and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_last_sample,
   output logic                 req_stall,
   input  pcc_pkg::status_type  status,
   output pcc_pkg::cmd_type     cmd
);

   pcc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcc_pkg::ST_LOAD: begin
            if (req_valid && req_last_sample) begin
               state_in = pcc_pkg::ST_TRAIL;
            end
         end
         pcc_pkg::ST_TRAIL: begin
            state_in = pcc_pkg::ST_SCAN;
         end
         pcc_pkg::ST_SCAN: begin
            if (status.peak_empty) begin
               state_in = pcc_pkg::ST_FINISH;
            end else if (status.scan_last) begin
               state_in = pcc_pkg::ST_DRAIN;
            end
         end
         pcc_pkg::ST_DRAIN: begin
            state_in = pcc_pkg::ST_FINISH;
         end
         pcc_pkg::ST_FINISH: begin
            if (!status.rsp_busy) begin
               state_in = pcc_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = pcc_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pcc_pkg::ST_LOAD: begin
            req_stall     = 1'b0;
            cmd.sample_en = req_valid;
         end
         pcc_pkg::ST_TRAIL: begin
            cmd.trail_en = 1'b1;
         end
         pcc_pkg::ST_SCAN: begin
            cmd.scan_rd = !status.peak_empty;
         end
         pcc_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         pcc_pkg::ST_FINISH: begin
            cmd.finish = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_datapath.sv =====
// ----------------------------------------------------------------------------
// pcc_datapath
// peak tracking, peak store, qualification counters and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_datapath (
   input  wire                                     clock,
   input  wire                                     reset,
   input  pcc_pkg::cmd_type                        cmd,
   output pcc_pkg::status_type                     status,
   input  wire signed [pcc_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  wire                                     rsp_stall,
   output logic                                    rsp_valid,
   output logic [pcc_pkg::COUNT_BITS-1:0]          rsp_cycle_count,
   output logic [pcc_pkg::COUNT_BITS-1:0]          rsp_positive_count,
   output logic [pcc_pkg::COUNT_BITS-1:0]          rsp_negative_count,
   output logic                                    rsp_overflow
);

   localparam int SB = pcc_pkg::SAMPLE_BITS;
   localparam int CB = pcc_pkg::COUNT_BITS;
   localparam int AB = pcc_pkg::ADDR_BITS;
   localparam int TB = pcc_pkg::TRIPLE_BITS;
   localparam logic [CB-1:0] MAX_CNT = CB'(pcc_pkg::MAX_WINDOW);

   // window state
   logic signed [SB-1:0] extreme_ff, extreme_in;
   logic signed [SB-1:0] prev_ff, prev_in;
   logic signed [SB-1:0] pos_ref_ff, pos_ref_in;
   logic signed [SB-1:0] neg_ref_ff, neg_ref_in;
   logic                 eip_ff, eip_in;
   logic                 started_ff, started_in;
   logic                 dropped_ff, dropped_in;
   logic [CB-1:0]        sample_total_ff, sample_total_in;
   logic [CB-1:0]        peak_total_ff, peak_total_in;

   // scan state
   logic [CB-1:0]        scan_idx_ff, scan_idx_in;
   logic                 rd_valid_ff;
   logic [CB-1:0]        pos_cnt_ff, pos_cnt_in;
   logic [CB-1:0]        neg_cnt_ff, neg_cnt_in;

   logic                      push_en;
   logic [pcc_pkg::PEAK_BITS-1:0] push_data;
   logic [pcc_pkg::PEAK_BITS-1:0] rd_data;
   logic signed [SB-1:0]      rd_value;
   logic signed [TB-1:0]      rd_triple;
   logic signed [TB-1:0]      pos_ref_ext;
   logic signed [TB-1:0]      neg_ref_ext;

   pcc_ram #(
      .WIDTH (pcc_pkg::PEAK_BITS),
      .DEPTH (pcc_pkg::MAX_WINDOW)
   ) u_peak_store (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (peak_total_ff[AB-1:0]),
      .wr_data (push_data),
      .rd_en   (cmd.scan_rd),
      .rd_addr (scan_idx_ff[AB-1:0]),
      .rd_data (rd_data)
   );

   // sample tracking and peak push
   always_comb begin
      extreme_in      = extreme_ff;
      prev_in         = prev_ff;
      pos_ref_in      = pos_ref_ff;
      neg_ref_in      = neg_ref_ff;
      eip_in          = eip_ff;
      started_in      = started_ff;
      dropped_in      = dropped_ff;
      sample_total_in = sample_total_ff;
      peak_total_in   = peak_total_ff;
      push_en         = 1'b0;
      push_data       = {1'b0, extreme_ff};

      if (cmd.sample_en) begin
         if (sample_total_ff < MAX_CNT) begin
            sample_total_in = sample_total_ff + 1'b1;
            if (!started_ff) begin
               extreme_in = req_sample;
               prev_in    = req_sample;
               pos_ref_in = req_sample;
               neg_ref_in = req_sample;
               eip_in     = 1'b1;
               started_in = 1'b1;
            end else begin
               eip_in  = 1'b0;
               prev_in = req_sample;
               if (req_sample > 0) begin
                  if (prev_ff > 0) begin
                     if (req_sample > extreme_ff) begin
                        extreme_in = req_sample;
                        eip_in     = 1'b1;
                     end
                  end else begin
                     push_en   = 1'b1;
                     push_data = {1'b0, extreme_ff};
                     if (extreme_ff < neg_ref_ff) begin
                        neg_ref_in = extreme_ff;
                     end
                     extreme_in = prev_ff;
                  end
               end else begin
                  if (prev_ff < 0) begin
                     if (req_sample < extreme_ff) begin
                        extreme_in = req_sample;
                        eip_in     = 1'b1;
                     end
                  end else begin
                     push_en   = 1'b1;
                     push_data = {1'b1, extreme_ff};
                     if (extreme_ff > pos_ref_ff) begin
                        pos_ref_in = extreme_ff;
                     end
                     extreme_in = prev_ff;
                  end
               end
            end
         end else begin
            dropped_in = 1'b1;
         end
      end

      // trailing extreme at window end
      if (cmd.trail_en && started_ff && !eip_ff) begin
         push_en   = 1'b1;
         push_data = {extreme_ff > 0, extreme_ff};
      end

      if (push_en && (peak_total_ff < MAX_CNT)) begin
         peak_total_in = peak_total_ff + 1'b1;
      end else begin
         push_en = 1'b0;
      end

      if (cmd.finish) begin
         extreme_in      = '0;
         prev_in         = '0;
         pos_ref_in      = '0;
         neg_ref_in      = '0;
         eip_in          = 1'b1;
         started_in      = 1'b0;
         dropped_in      = 1'b0;
         sample_total_in = '0;
         peak_total_in   = '0;
      end
   end

   // qualification of stored peaks
   assign rd_value    = rd_data[SB-1:0];
   assign rd_triple   = TB'(rd_value) + (TB'(rd_value) <<< 1);
   assign pos_ref_ext = TB'(pos_ref_ff);
   assign neg_ref_ext = TB'(neg_ref_ff);

   always_comb begin
      scan_idx_in = scan_idx_ff;
      pos_cnt_in  = pos_cnt_ff;
      neg_cnt_in  = neg_cnt_ff;
      if (cmd.trail_en) begin
         scan_idx_in = '0;
         pos_cnt_in  = '0;
         neg_cnt_in  = '0;
      end else begin
         if (cmd.scan_rd) begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
         if (rd_valid_ff) begin
            if (rd_data[SB]) begin
               if (rd_triple > pos_ref_ext) begin
                  pos_cnt_in = pos_cnt_ff + 1'b1;
               end
            end else begin
               if (rd_triple < neg_ref_ext) begin
                  neg_cnt_in = neg_cnt_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         extreme_ff      <= '0;
         prev_ff         <= '0;
         pos_ref_ff      <= '0;
         neg_ref_ff      <= '0;
         eip_ff          <= 1'b1;
         started_ff      <= 1'b0;
         dropped_ff      <= 1'b0;
         sample_total_ff <= '0;
         peak_total_ff   <= '0;
         scan_idx_ff     <= '0;
         rd_valid_ff     <= 1'b0;
         pos_cnt_ff      <= '0;
         neg_cnt_ff      <= '0;
      end else begin
         extreme_ff      <= extreme_in;
         prev_ff         <= prev_in;
         pos_ref_ff      <= pos_ref_in;
         neg_ref_ff      <= neg_ref_in;
         eip_ff          <= eip_in;
         started_ff      <= started_in;
         dropped_ff      <= dropped_in;
         sample_total_ff <= sample_total_in;
         peak_total_ff   <= peak_total_in;
         scan_idx_ff     <= scan_idx_in;
         rd_valid_ff     <= cmd.scan_rd;
         pos_cnt_ff      <= pos_cnt_in;
         neg_cnt_ff      <= neg_cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_positive_count <= pos_cnt_ff;
         rsp_negative_count <= neg_cnt_ff;
         rsp_cycle_count    <= (pos_cnt_ff > neg_cnt_ff) ? neg_cnt_ff : pos_cnt_ff;
         rsp_overflow       <= dropped_ff;
      end
   end

   assign status.peak_empty = (peak_total_ff == '0);
   assign status.scan_last  = ((scan_idx_ff + 1'b1) == peak_total_ff);
   assign status.rsp_busy   = rsp_valid && rsp_stall;

`ifndef ASSERT_OFF
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      peak_total_ff <= MAX_CNT)
      else $error("peak total above window size");

   a_peaks_vs_samples: assert property (@(posedge clock) disable iff (reset)
      peak_total_ff <= sample_total_ff)
      else $error("more peaks than samples");

   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (peak_total_ff == '0))
      else $error("peaks stored before window start");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pulse_cycle_counter.sv =====
// ----------------------------------------------------------------------------
// pulse_cycle_counter
// counts oscillation cycles of a pulse window from its alternating peaks
// ----------------------------------------------------------------------------
// Sample transactions are accepted without stall while the window loads. After
// the sample marked last, the block stalls its input through its states in
// order: trail stores a trailing peak, scan reads each stored peak from the
// peak ram through its single read port, drain takes in the last registered
// read and finish loads the result register (an empty window goes from scan
// straight to finish, with no drain). The result waits in its own register,
// so the next window starts loading while the previous result is pending; the
// load of the next result waits for as long as that earlier result stays
// stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_cycle_counter (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire signed [pcc_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  wire                                     req_last_sample,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic [pcc_pkg::COUNT_BITS-1:0]          rsp_cycle_count,
   output logic [pcc_pkg::COUNT_BITS-1:0]          rsp_positive_count,
   output logic [pcc_pkg::COUNT_BITS-1:0]          rsp_negative_count,
   output logic                                    rsp_overflow
);

   pcc_pkg::cmd_type    cmd;
   pcc_pkg::status_type status;

   pcc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .status          (status),
      .cmd             (cmd)
   );

   pcc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sample         (req_sample),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_cycle_count    (rsp_cycle_count),
      .rsp_positive_count (rsp_positive_count),
      .rsp_negative_count (rsp_negative_count),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

`default_nettype wire

// ===== test/pulse_cycle_counter_tb.sv =====
// ----------------------------------------------------------------------------
// pulse_cycle_counter_tb
// self-checking bench for the pulse cycle counter
// ----------------------------------------------------------------------------
// Drives windows of signed samples with random idle cycles on the sample side
// and random stalls on the result side. A scoreboard tracks the peaks of each
// window as its samples are accepted and predicts the qualified positive and
// negative peak counts, the cycle count and the overflow flag, then checks
// each result transaction against the oldest prediction. Stimulus runs from
// directed corner windows through random oscillating and noise windows.
// ----------------------------------------------------------------------------

module pulse_cycle_counter_tb;

   localparam int IDLE_PCT      = 15;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 20;
   localparam int COUNT_SAT     = 8191;
   localparam int CB            = pcc_pkg::COUNT_BITS;

   typedef struct packed {
      logic [pcc_pkg::COUNT_BITS-1:0] cycles;
      logic [pcc_pkg::COUNT_BITS-1:0] positive;
      logic [pcc_pkg::COUNT_BITS-1:0] negative;
      logic                           overflow;
   } count_result_type;

   class cycle_count_scoreboard_type;
      int               peak_val [pcc_pkg::MAX_WINDOW];
      bit               peak_pos [pcc_pkg::MAX_WINDOW];
      int               peak_cnt;
      int               extreme;
      bit               extreme_fresh;
      int               previous;
      int               ref_pos;
      int               ref_neg;
      bit               started;
      int               sample_cnt;
      bit               dropped;
      count_result_type result_q [$];
      int               errors;

      function new();
         errors = 0;
         clear_window();
      endfunction

      function void clear_window();
         peak_cnt      = 0;
         extreme       = 0;
         extreme_fresh = 1'b1;
         previous      = 0;
         ref_pos       = 0;
         ref_neg       = 0;
         started       = 1'b0;
         sample_cnt    = 0;
         dropped       = 1'b0;
      endfunction

      function void store_peak(int v, bit positive);
         if (peak_cnt < pcc_pkg::MAX_WINDOW) begin
            peak_val[peak_cnt] = v;
            peak_pos[peak_cnt] = positive;
            peak_cnt++;
         end
      endfunction

      function void track_sample(int s);
         if (!started) begin
            extreme       = s;
            previous      = s;
            ref_pos       = s;
            ref_neg       = s;
            extreme_fresh = 1'b1;
            started       = 1'b1;
            return;
         end
         extreme_fresh = 1'b0;
         if (s > 0) begin
            if (previous > 0) begin
               if (s > extreme) begin
                  extreme       = s;
                  extreme_fresh = 1'b1;
               end
            end else begin
               store_peak(extreme, 1'b0);
               if (extreme < ref_neg) ref_neg = extreme;
               extreme = previous;
            end
         end else begin
            if (previous < 0) begin
               if (s < extreme) begin
                  extreme       = s;
                  extreme_fresh = 1'b1;
               end
            end else begin
               store_peak(extreme, 1'b1);
               if (extreme > ref_pos) ref_pos = extreme;
               extreme = previous;
            end
         end
         previous = s;
      endfunction

      // one accepted sample transaction
      function void note_sample(logic signed [pcc_pkg::SAMPLE_BITS-1:0] s, logic last);
         count_result_type r;
         int               pos;
         int               neg;
         if (sample_cnt < pcc_pkg::MAX_WINDOW) begin
            track_sample(int'(s));
            sample_cnt++;
         end else begin
            dropped = 1'b1;
         end
         if (!last) return;
         // trailing extreme goes in by its sign, references untouched
         if (started && !extreme_fresh) store_peak(extreme, extreme > 0);
         pos = 0;
         neg = 0;
         for (int i = 0; i < peak_cnt; i++) begin
            if (peak_pos[i]) begin
               if (3 * peak_val[i] > ref_pos) pos++;
            end else begin
               if (3 * peak_val[i] < ref_neg) neg++;
            end
         end
         if (pos > COUNT_SAT) pos = COUNT_SAT;
         if (neg > COUNT_SAT) neg = COUNT_SAT;
         r.positive = CB'(pos);
         r.negative = CB'(neg);
         r.cycles   = CB'((pos > neg) ? neg : pos);
         r.overflow = dropped;
         result_q.insert(result_q.size(), r);
         clear_window();
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // one accepted result transaction
      function void check_counts(count_result_type got);
         count_result_type want;
         if (result_q.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual cycle_count %0d",
                     $time, got.cycles);
            errors++;
            return;
         end
         want = result_q.pop_front();
         compare_field("cycle_count", int'(want.cycles), int'(got.cycles));
         compare_field("positive_count", int'(want.positive), int'(got.positive));
         compare_field("negative_count", int'(want.negative), int'(got.negative));
         compare_field("overflow", int'(want.overflow), int'(got.overflow));
      endfunction
   endclass

   logic                                   clock           = 1'b0;
   logic                                   reset           = 1'b1;
   logic                                   req_valid       = 1'b0;
   logic                                   req_stall;
   logic signed [pcc_pkg::SAMPLE_BITS-1:0] req_sample      = '0;
   logic                                   req_last_sample = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_stall       = 1'b0;
   logic [pcc_pkg::COUNT_BITS-1:0]         rsp_cycle_count;
   logic [pcc_pkg::COUNT_BITS-1:0]         rsp_positive_count;
   logic [pcc_pkg::COUNT_BITS-1:0]         rsp_negative_count;
   logic                                   rsp_overflow;

   cycle_count_scoreboard_type board;
   bit                         idle_en     = 1'b1;
   int                         items_sent  = 0;
   int                         quiet_count = 0;

   pulse_cycle_counter u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_last_sample    (req_last_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cycle_count    (rsp_cycle_count),
      .rsp_positive_count (rsp_positive_count),
      .rsp_negative_count (rsp_negative_count),
      .rsp_overflow       (rsp_overflow)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_counts({rsp_cycle_count, rsp_positive_count, rsp_negative_count,
                             rsp_overflow});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   task automatic send_sample(input int s, input bit last);
      while (idle_en && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= s[pcc_pkg::SAMPLE_BITS-1:0];
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(req_sample, req_last_sample);
      items_sent++;
   endtask

   task automatic send_window(input int vals [$]);
      for (int i = 0; i < vals.size(); i++) send_sample(vals[i], i == vals.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.result_q.size() != 0) @(posedge clock);
   endtask

   // oscillating window with random half-cycle lengths, or plain noise
   task automatic random_window();
      int len;
      int amp;
      int left;
      int s;
      bit positive;
      if ($urandom_range(99) < 15) begin
         len = $urandom_range(1, 30);
         for (int i = 0; i < len; i++)
            send_sample(int'($urandom_range(65535)) - 32768, i == len - 1);
      end else begin
         len      = ($urandom_range(99) < 90) ? $urandom_range(2, 40) : $urandom_range(41, 300);
         amp      = $urandom_range(1, 32767);
         positive = $urandom_range(1);
         left     = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            if (left == 0) begin
               positive = !positive;
               left     = $urandom_range(1, 6);
               if ($urandom_range(3) == 0) amp = $urandom_range(1, 32767);
            end
            s = $urandom_range(amp);
            if (!positive) s = ($urandom_range(49) == 0) ? -32768 : -s;
            send_sample(s, i == len - 1);
            left--;
         end
      end
   endtask

   initial begin
      int random_start;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single sample windows, zeros, sign flips, trailing extremes, full scale
      send_window('{32767});
      send_window('{-32768});
      send_window('{0, 0, 0});
      send_window('{1, -1, 0, 1, -1});
      send_window('{300, 200, 100});
      send_window('{-5, -9, -2, 7, 3});
      send_window('{32767, -32768, 32767, -32768});
      wait_drained();

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         idle_en = !((items_sent - random_start) inside {[600:900]});
         random_window();
         if ($urandom_range(19) == 0) wait_drained();
      end
      idle_en = 1'b1;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
